// ===== sv/rcwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column projection: shared package
// Screen geometry, fixed-point formats, register indexes and the sideband
// record that travels down the divider pipeline.
// ----------------------------------------------------------------------------
package rcwp_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;

  // Angles in 1/16 degree steps
  localparam int TURN    = 5760;
  localparam int QUARTER = 1440;
  localparam int ANG_W   = 13;

  // Sine table: sin(k/16 deg), k = 0..QUARTER, unsigned Q1.30
  localparam int ROM_DEPTH = QUARTER + 1;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int ROM_W     = 31;
  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint HALF_Q30 = 64'sd1 << 29;
  localparam longint STEP_COS = 64'sd1073741185;
  localparam longint STEP_SIN = 64'sd1171270;
  // STEP_COS = ONE_Q30 - COS_DEFICIT, so s * STEP_COS = (s << 30) - s * COS_DEFICIT
  localparam longint COS_DEFICIT = ONE_Q30 - STEP_COS;
  localparam int KSIN_W = 23;
  localparam int KDEF_W = 11;

  // Field widths
  localparam int COL_W      = 10;
  localparam int DIST_W     = 24;
  localparam int FOV_W      = 8;
  localparam int BLK_W      = 11;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Field of view clamp; half the field of view in sixteenths is fov << 3
  localparam int FOV_MIN   = 1;
  localparam int FOV_MAX   = 179;
  localparam int FOV_SHIFT = 3;

  // Height = block * NUM_SCALE * cos(h) / (corrected * sin(h))
  localparam int NUM_SCALE = 256 * (SCREEN_WIDTH / 2);
  localparam int BC_W      = BLK_W + ROM_W;
  localparam int NUM_W     = BC_W + $clog2(NUM_SCALE + 1);
  localparam int DEN_W     = DIST_W + ROM_W;
  localparam int DIV_W     = DEN_W + HEIGHT_W + 1;
  localparam int TOP_W     = HEIGHT_W + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK   = 2'd2;

  // Per-column sideband carried alongside the division
  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [DIST_W-1:0] corrected;
  } rcwp_side_t;

endpackage

// ===== sv/rcwp_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column projection: sine table
// Builds the quarter-wave sine table after reset with a rotation recurrence
// (product, sum and rounding states per entry) and serves two registered read ports.
// ----------------------------------------------------------------------------
module rcwp_sine_rom import rcwp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              ready_o,
  input  logic [ROM_AW-1:0] rd_a_addr_i,
  output logic [ROM_W-1:0]  rd_a_data_o,
  input  logic [ROM_AW-1:0] rd_b_addr_i,
  output logic [ROM_W-1:0]  rd_b_data_o
);

  typedef enum logic [2:0] {
    INIT_ZERO,
    INIT_MUL,
    INIT_SUM,
    INIT_RND,
    INIT_DONE
  } init_state_e;

  localparam logic signed [KSIN_W-1:0] K_SIN = KSIN_W'(STEP_SIN);
  localparam logic signed [KDEF_W-1:0] K_DEF = KDEF_W'(COS_DEFICIT);
  localparam int PROD_W = 32 + KSIN_W;

  init_state_e state_q, state_d;
  logic [ROM_AW-1:0] k_q, k_d;
  logic signed [31:0] s_q, s_d, c_q, c_d;
  logic signed [PROD_W-1:0] p_sd_q, p_cs_q, p_cd_q, p_ss_q;
  logic signed [63:0] xs_q, xc_q;
  logic ready_q;

  logic signed [31:0] ns, nc;
  logic [ROM_W-1:0] ns_clamp;
  logic              mem_we;
  logic [ROM_AW-1:0] mem_waddr;
  logic [ROM_W-1:0]  mem_wdata;

  logic [ROM_W-1:0] mem [ROM_DEPTH];
  logic [ROM_W-1:0] rd_a_q, rd_b_q;

  // Round half away from zero, dropping 30 fraction bits
  function automatic logic signed [31:0] round_q30(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] rm;
    logic signed [31:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    rm  = (mag + 64'(HALF_Q30)) >> 30;
    r   = $signed(rm[31:0]);
    return x[63] ? -r : r;
  endfunction

  always_comb begin
    ns = round_q30(xs_q);
    nc = round_q30(xc_q);
    if (ns < 0) begin
      ns_clamp = '0;
    end else if (64'(ns) > ONE_Q30) begin
      ns_clamp = ROM_W'(ONE_Q30);
    end else begin
      ns_clamp = ns[ROM_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    s_d     = s_q;
    c_d     = c_q;
    unique case (state_q)
      INIT_ZERO: state_d = INIT_MUL;
      INIT_MUL:  state_d = INIT_SUM;
      INIT_SUM:  state_d = INIT_RND;
      INIT_RND: begin
        s_d = ns;
        c_d = nc;
        if (k_q == ROM_AW'(QUARTER)) begin
          state_d = INIT_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = INIT_MUL;
        end
      end
      INIT_DONE: state_d = INIT_DONE;
      default:   state_d = INIT_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= INIT_ZERO;
      k_q     <= ROM_AW'(1);
      s_q     <= '0;
      c_q     <= 32'(ONE_Q30);
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      s_q     <= s_d;
      c_q     <= c_d;
      ready_q <= (state_d == INIT_DONE);
    end
  end

  // Recurrence datapath: products, then sums, then rounding
  always_ff @(posedge clk_i) begin
    if (state_q == INIT_MUL) begin
      p_sd_q <= s_q * K_DEF;
      p_cs_q <= c_q * K_SIN;
      p_cd_q <= c_q * K_DEF;
      p_ss_q <= s_q * K_SIN;
    end
    if (state_q == INIT_SUM) begin
      xs_q <= (64'(s_q) <<< 30) - 64'(p_sd_q) + 64'(p_cs_q);
      xc_q <= (64'(c_q) <<< 30) - 64'(p_cd_q) - 64'(p_ss_q);
    end
  end

  assign mem_we    = (state_q == INIT_ZERO) || (state_q == INIT_RND);
  assign mem_waddr = (state_q == INIT_ZERO) ? '0 : k_q;
  assign mem_wdata = (state_q == INIT_ZERO) ? '0 : ns_clamp;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign ready_o     = ready_q;
  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// ===== sv/rcwp_divider.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column projection: pipelined height divider
// One saturation check stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module rcwp_divider import rcwp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rcwp_side_t          side_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic                valid_o,
  output rcwp_side_t          side_o,
  output logic [HEIGHT_W-1:0] quot_o,
  output logic                sat_o
);

  localparam int STAGES = HEIGHT_W + 1;

  logic                valid_q [STAGES];
  rcwp_side_t          side_q  [STAGES];
  logic [DIV_W-1:0]    rem_q   [STAGES];
  logic [DEN_W-1:0]    den_q   [STAGES];
  logic [HEIGHT_W-1:0] quot_q  [STAGES];
  logic                sat_q   [STAGES];

  // Saturate when the quotient would need more than HEIGHT_W bits (or den is zero)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    rem_q[0]  <= DIV_W'(num_i);
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    sat_q[0]  <= DIV_W'(num_i) >= (DIV_W'(den_i) << HEIGHT_W);
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    localparam int BIT = HEIGHT_W - k;
    logic [DIV_W-1:0]    shifted;
    logic                fits;
    logic [HEIGHT_W-1:0] quot_d;

    always_comb begin
      shifted     = DIV_W'(den_q[k-1]) << BIT;
      fits        = rem_q[k-1] >= shifted;
      quot_d      = quot_q[k-1];
      quot_d[BIT] = fits;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
      rem_q[k]  <= fits ? (rem_q[k-1] - shifted) : rem_q[k-1];
      den_q[k]  <= den_q[k-1];
      quot_q[k] <= quot_d;
      sat_q[k]  <= sat_q[k-1];
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];
  assign quot_o  = quot_q[STAGES-1];
  assign sat_o   = sat_q[STAGES-1];

endmodule

// ===== sv/raycast_wall_column_projection.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column projection
// Fisheye-corrected wall height and vertical extent for one screen column.
// ----------------------------------------------------------------------------
// Usage: pulse start with a column, its ray angle and raw hit distance while
// busy is low; the column is taken in that cycle and one column can follow in
// every cycle. Each result passes stages 1 to 4, the divider stages and the
// output register, then shows on the result ports for a single cycle with
// result_valid_o high; the receiver cannot stall, so capture it then. After
// reset, busy stays high while the sine table is built (a zero entry, then
// a product, sum and rounding step per entry), its ready flag is seen and
// the field of view terms are fetched. A write of field_of_view raises busy
// again while sin and cos of half the field of view are fetched from the
// table's second read port. Write registers only while no column is in flight.
// ----------------------------------------------------------------------------
module raycast_wall_column_projection import rcwp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Column command
  input  logic                  start,
  output logic                  busy,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ANG_W-1:0]      ray_angle_i,
  input  logic [DIST_W-1:0]     raw_distance_i,
  // Result
  output logic                  result_valid_o,
  output logic [COL_W-1:0]      out_column_o,
  output logic signed [HEIGHT_W-1:0] wall_top_o,
  output logic [HEIGHT_W-1:0]   wall_bottom_o,
  output logic [DIST_W-1:0]     corrected_distance_o,
  output logic                  height_saturated_o
);

  typedef enum logic [2:0] {
    REF_WAIT,
    REF_SIN,
    REF_COS,
    REF_CAP,
    REF_RUN
  } ref_state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ANG_W-1:0] heading_q;
  logic [FOV_W-1:0] fov_q;
  logic [BLK_W-1:0] block_q;
  logic             cfg_xfer;
  logic             fov_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign fov_write   = cfg_xfer && (cfg_index_i == REG_FOV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      fov_q     <= FOV_W'(60);
      block_q   <= BLK_W'(64);
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_HEADING: heading_q <= cfg_data_i[ANG_W-1:0];
        REG_FOV:     fov_q     <= cfg_data_i[FOV_W-1:0];
        REG_BLOCK:   block_q   <= cfg_data_i[BLK_W-1:0];
        default:     ; // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sine table
  // --------------------------------------------------------------------------
  logic              rom_ready;
  logic [ROM_AW-1:0] rom_a_addr, rom_b_addr;
  logic [ROM_W-1:0]  rom_a_data, rom_b_data;

  rcwp_sine_rom u_rom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (rom_ready),
    .rd_a_addr_i (rom_a_addr),
    .rd_a_data_o (rom_a_data),
    .rd_b_addr_i (rom_b_addr),
    .rd_b_data_o (rom_b_data)
  );

  // --------------------------------------------------------------------------
  // Field of view terms: sin(h) and cos(h), h = half the field of view.
  // Refetch after the table is built and after every field_of_view write.
  // --------------------------------------------------------------------------
  ref_state_e        ref_state_q, ref_state_d;
  logic [ROM_W-1:0]  sin_h_q, cos_h_q;
  logic [FOV_W-1:0]  fov_c;
  logic [ROM_AW-1:0] half_fov;

  always_comb begin
    if (fov_q < FOV_W'(FOV_MIN)) begin
      fov_c = FOV_W'(FOV_MIN);
    end else if (fov_q > FOV_W'(FOV_MAX)) begin
      fov_c = FOV_W'(FOV_MAX);
    end else begin
      fov_c = fov_q;
    end
    half_fov   = ROM_AW'(fov_c) << FOV_SHIFT;
    rom_b_addr = (ref_state_q == REF_COS) ? (ROM_AW'(QUARTER) - half_fov) : half_fov;
  end

  always_comb begin
    ref_state_d = ref_state_q;
    unique case (ref_state_q)
      REF_WAIT: if (rom_ready) ref_state_d = REF_SIN;
      REF_SIN:  ref_state_d = REF_COS;
      REF_COS:  ref_state_d = REF_CAP;
      REF_CAP:  ref_state_d = REF_RUN;
      REF_RUN:  ref_state_d = REF_RUN;
      default:  ref_state_d = REF_WAIT;
    endcase
    // restart the fetch on a new field of view once the table exists
    if (fov_write && (ref_state_q != REF_WAIT)) begin
      ref_state_d = REF_SIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_state_q <= REF_WAIT;
      sin_h_q     <= '0;
      cos_h_q     <= '0;
    end else begin
      ref_state_q <= ref_state_d;
      if (ref_state_q == REF_COS) begin
        sin_h_q <= rom_b_data;
      end
      if (ref_state_q == REF_CAP) begin
        cos_h_q <= rom_b_data;
      end
    end
  end

  assign busy = (ref_state_q != REF_RUN);

  // --------------------------------------------------------------------------
  // Stage 1: wrap the ray angle relative to the heading into one turn
  // --------------------------------------------------------------------------
  logic             accept;
  logic [ANG_W-1:0] ray_m, head_m, diff;

  assign accept = start & ~busy;

  always_comb begin
    ray_m  = (ray_angle_i >= ANG_W'(TURN)) ? (ray_angle_i - ANG_W'(TURN)) : ray_angle_i;
    head_m = (heading_q >= ANG_W'(TURN)) ? (heading_q - ANG_W'(TURN)) : heading_q;
    diff   = (ray_m >= head_m) ? (ray_m - head_m) : (ray_m + ANG_W'(TURN) - head_m);
  end

  logic              s1_valid_q;
  logic [COL_W-1:0]  s1_column_q;
  logic [DIST_W-1:0] s1_raw_q;
  logic [ANG_W-1:0]  s1_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_column_q <= column_i;
    s1_raw_q    <= raw_distance_i;
    s1_diff_q   <= diff;
  end

  // --------------------------------------------------------------------------
  // Stage 2: |cos(diff)| by quadrant symmetry; the table registers the read
  // --------------------------------------------------------------------------
  logic [ANG_W-1:0] rem_ang;
  logic             odd_quadrant;

  always_comb begin
    if (s1_diff_q >= ANG_W'(3 * QUARTER)) begin
      rem_ang      = s1_diff_q - ANG_W'(3 * QUARTER);
      odd_quadrant = 1'b1;
    end else if (s1_diff_q >= ANG_W'(2 * QUARTER)) begin
      rem_ang      = s1_diff_q - ANG_W'(2 * QUARTER);
      odd_quadrant = 1'b0;
    end else if (s1_diff_q >= ANG_W'(QUARTER)) begin
      rem_ang      = s1_diff_q - ANG_W'(QUARTER);
      odd_quadrant = 1'b1;
    end else begin
      rem_ang      = s1_diff_q;
      odd_quadrant = 1'b0;
    end
    rom_a_addr = odd_quadrant ? rem_ang[ROM_AW-1:0]
                              : (ROM_AW'(QUARTER) - rem_ang[ROM_AW-1:0]);
  end

  logic              s2_valid_q;
  logic [COL_W-1:0]  s2_column_q;
  logic [DIST_W-1:0] s2_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_column_q <= s1_column_q;
    s2_raw_q    <= s1_raw_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: corrected distance = raw * |cos| >> 30; numerator partial
  // --------------------------------------------------------------------------
  logic [DIST_W+ROM_W-1:0] corr_prod;
  logic                    s3_valid_q;
  rcwp_side_t              s3_side_q;
  logic [BC_W-1:0]         s3_bc_q;

  assign corr_prod = (DIST_W+ROM_W)'(s2_raw_q) * (DIST_W+ROM_W)'(rom_a_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_side_q.column    <= s2_column_q;
    s3_side_q.corrected <= corr_prod[DIST_W+29:30];
    s3_bc_q             <= BC_W'(block_q) * BC_W'(cos_h_q);
  end

  // --------------------------------------------------------------------------
  // Stage 4: numerator and denominator of the wall height
  // --------------------------------------------------------------------------
  logic              s4_valid_q;
  rcwp_side_t        s4_side_q;
  logic [NUM_W-1:0]  s4_num_q;
  logic [DEN_W-1:0]  s4_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= s3_side_q;
    s4_num_q  <= NUM_W'(s3_bc_q) * NUM_W'(NUM_SCALE);
    s4_den_q  <= DEN_W'(s3_side_q.corrected) * DEN_W'(sin_h_q);
  end

  // --------------------------------------------------------------------------
  // Stages 5..21: saturation check and quotient bits
  // --------------------------------------------------------------------------
  logic                div_valid;
  rcwp_side_t          div_side;
  logic [HEIGHT_W-1:0] div_quot;
  logic                div_sat;

  rcwp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid_q),
    .side_i  (s4_side_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .valid_o (div_valid),
    .side_o  (div_side),
    .quot_o  (div_quot),
    .sat_o   (div_sat)
  );

  // --------------------------------------------------------------------------
  // Output stage: center the wall vertically
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0]    height;
  logic signed [TOP_W-1:0] top_full, bottom_full;

  always_comb begin
    height      = div_sat ? '1 : div_quot;
    top_full    = TOP_W'(HALF_H) - TOP_W'(height >> 1);
    bottom_full = top_full + TOP_W'(height);
  end

  logic                res_valid_q;
  logic [COL_W-1:0]    res_column_q;
  logic [HEIGHT_W-1:0] res_top_q, res_bottom_q;
  logic [DIST_W-1:0]   res_corr_q;
  logic                res_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_column_q <= div_side.column;
    res_top_q    <= top_full[HEIGHT_W-1:0];
    res_bottom_q <= bottom_full[HEIGHT_W-1:0];
    res_corr_q   <= div_side.corrected;
    res_sat_q    <= div_sat;
  end

  assign result_valid_o       = res_valid_q;
  assign out_column_o         = res_column_q;
  assign wall_top_o           = $signed(res_top_q);
  assign wall_bottom_o        = res_bottom_q;
  assign corrected_distance_o = res_corr_q;
  assign height_saturated_o   = res_sat_q;

endmodule

// ===== dv/tb_raycast_wall_column_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycast wall column projection testbench
// Sends screen columns through the command port and predicts each one's wall
// span in the testbench: its own sine table built by the rotation recurrence,
// the fisheye correction and the height division. Every result strobe is
// checked against the oldest pending prediction. Directed cases cover the
// reset settings, angle wrap, distance and register extremes. Random frames
// follow, each with new registers, sender gaps in most and a full drain.
// ----------------------------------------------------------------------------
module tb_raycast_wall_column_projection;
  import rcwp_pkg::*;

  localparam int          HALF_PERIOD = 2;
  localparam int          RESET_CYCLES = 6;
  localparam int          FRAMES = 15;
  localparam int          COLUMNS_PER_FRAME = 110;
  localparam int          MAX_GAP = 19;
  localparam int          TAIL_CYCLES = 40;     // pipeline is 22 deep
  localparam int unsigned STALL_LIMIT = 20000;  // outlasts the table build after reset
  localparam int          MAX_REPORTS = 10;
  localparam int          ANG_MAX = (1 << ANG_W) - 1;
  localparam longint unsigned HEIGHT_MAX = (64'd1 << HEIGHT_W) - 1;
  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One predicted wall span, laid out as the result ports
  typedef struct packed {
    logic [COL_W-1:0]    column;
    logic [HEIGHT_W-1:0] top;
    logic [HEIGHT_W-1:0] bottom;
    logic [DIST_W-1:0]   corrected;
    logic                saturated;
  } wall_span_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  start;
  logic                  busy;
  logic [COL_W-1:0]      column_i;
  logic [ANG_W-1:0]      ray_angle_i;
  logic [DIST_W-1:0]     raw_distance_i;
  logic                  result_valid_o;
  logic [COL_W-1:0]      out_column_o;
  logic signed [HEIGHT_W-1:0] wall_top_o;
  logic [HEIGHT_W-1:0]   wall_bottom_o;
  logic [DIST_W-1:0]     corrected_distance_o;
  logic                  height_saturated_o;

  // Predictor copy of the registers, reset values
  logic [ANG_W-1:0] heading_reg = 13'd0;
  logic [FOV_W-1:0] fov_reg = 8'd60;
  logic [BLK_W-1:0] block_reg = 11'd64;

  logic [ROM_W-1:0] sine_tab [ROM_DEPTH];
  wall_span_t       pending_spans [$];
  int               error_count = 0;
  int unsigned      quiet_cycles = 0;
  bit               sender_gaps = 1'b0;

  raycast_wall_column_projection DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .start                (start),
    .busy                 (busy),
    .column_i             (column_i),
    .ray_angle_i          (ray_angle_i),
    .raw_distance_i       (raw_distance_i),
    .result_valid_o       (result_valid_o),
    .out_column_o         (out_column_o),
    .wall_top_o           (wall_top_o),
    .wall_bottom_o        (wall_bottom_o),
    .corrected_distance_o (corrected_distance_o),
    .height_saturated_o   (height_saturated_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Round a Q60 product back to Q30, half away from zero
  function automatic longint round_q30(longint x);
    if (x >= 0) begin
      return (x + HALF_Q30) / ONE_Q30;
    end
    return -((-x + HALF_Q30) / ONE_Q30);
  endfunction

  // Rotate (cos, sin) by 1/16 degree per step; clamp each stored sine to 0..1
  function automatic void build_sine_table();
    longint s, c, ns, nc;
    s = 0;
    c = ONE_Q30;
    sine_tab[0] = '0;
    for (int k = 1; k <= QUARTER; k++) begin
      ns = round_q30(s * STEP_COS + c * STEP_SIN);
      nc = round_q30(c * STEP_COS - s * STEP_SIN);
      s = ns;
      c = nc;
      sine_tab[k] = (s < 0) ? '0 : ((s > ONE_Q30) ? ROM_W'(ONE_Q30) : ROM_W'(s));
    end
  endfunction

  // |cos| of an angle in 0..TURN-1 by quadrant symmetry
  function automatic longint unsigned abs_cosine(int unsigned a);
    int unsigned quadrant, rest;
    quadrant = (a / QUARTER) % 4;
    rest = a % QUARTER;
    if (quadrant == 0 || quadrant == 2) begin
      return sine_tab[QUARTER - rest];
    end
    return sine_tab[rest];
  endfunction

  function automatic wall_span_t project_column(logic [COL_W-1:0] column,
                                                logic [ANG_W-1:0] ray,
                                                logic [DIST_W-1:0] raw);
    wall_span_t      span;
    int unsigned     diff, fov, half_fov;
    longint unsigned corrected, height, num, den;
    longint          top;
    logic            sat;
    diff = ((int'(ray) % TURN) + TURN - (int'(heading_reg) % TURN)) % TURN;
    corrected = (longint'(raw) * abs_cosine(diff)) >> 30;
    fov = fov_reg;
    if (fov < FOV_MIN) fov = FOV_MIN;
    if (fov > FOV_MAX) fov = FOV_MAX;
    half_fov = fov << FOV_SHIFT;
    sat = 1'b0;
    if (corrected == 0) begin
      height = HEIGHT_MAX;
      sat = 1'b1;
    end else begin
      num = longint'(block_reg) * longint'(NUM_SCALE)
            * longint'(sine_tab[QUARTER - half_fov]);
      den = corrected * longint'(sine_tab[half_fov]);
      height = (den != 0) ? num / den : HEIGHT_MAX;
      if (den == 0 || height > HEIGHT_MAX) begin
        height = HEIGHT_MAX;
        sat = 1'b1;
      end
    end
    // Center the wall vertically; wrap both rows to 16 bits
    top = longint'(HALF_H) - longint'(height / 2);
    span.column    = column;
    span.top       = HEIGHT_W'(top);
    span.bottom    = HEIGHT_W'(top + longint'(height));
    span.corrected = DIST_W'(corrected);
    span.saturated = sat;
    return span;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes are sampled on the
  // rising edge (DUT flops update after the TB reads them in that step)
  // --------------------------------------------------------------------------

  // Send one column; hold start high across back-to-back transfers
  task automatic send_column(logic [COL_W-1:0] column, logic [ANG_W-1:0] ray,
                             logic [DIST_W-1:0] raw);
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    column_i       <= column;
    ray_angle_i    <= ray;
    raw_distance_i <= raw;
    do @(posedge clk_i); while (busy);
    pending_spans.push_back(project_column(column, ray, raw));
  endtask

  // Drop start and wait until every predicted span has been checked
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  // Write one register once the pipeline is empty, then mirror it
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, int unsigned value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_HEADING: heading_reg = ANG_W'(value);
      REG_FOV:     fov_reg = FOV_W'(value);
      REG_BLOCK:   block_reg = BLK_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hit distance with a random bit length, so every height range shows up
  function automatic logic [DIST_W-1:0] random_distance();
    int unsigned bits;
    bits = $urandom_range(0, DIST_W);
    if (bits == 0) begin
      return '0;
    end
    return DIST_W'($urandom() & ((32'd1 << bits) - 32'd1));
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void log_error(string msg);
    if (error_count < MAX_REPORTS) begin
      $display("%s", msg);
    end
    error_count++;
  endfunction

  always @(posedge clk_i) begin
    wall_span_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{out_column_o, wall_top_o, wall_bottom_o, corrected_distance_o,
              height_saturated_o};
      if (pending_spans.size() == 0) begin
        log_error($sformatf("unexpected result for column %0d", out_column_o));
      end else begin
        want = pending_spans.pop_front();
        if (got !== want) begin
          log_error($sformatf({"mismatch: expected col %0d top %0d bottom %0d ",
                               "dist %0h sat %0b, got col %0d top %0d bottom %0d ",
                               "dist %0h sat %0b"},
                              want.column, $signed(want.top), want.bottom,
                              want.corrected, want.saturated, got.column,
                              $signed(got.top), got.bottom, got.corrected,
                              got.saturated));
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers untouched since reset: heading 0, 60 degree view, block 64
  task automatic test_reset_values();
    send_column(10'd0, 13'd0, 24'd0);
    send_column(10'd512, 13'd0, 24'd25600);
    send_column(10'd1023, 13'd160, 24'hFFFFFF);
  endtask

  // Ray straight ahead, at right angles, behind, and angles past one turn
  task automatic test_angle_wrap();
    write_reg(REG_HEADING, 5000);
    send_column(10'd1, 13'd5000, 24'd12800);
    send_column(10'd2, 13'd680, 24'd12800);   // perpendicular: cos is zero
    send_column(10'd3, 13'd2120, 24'd12800);  // half a turn: cos is -1
    send_column(10'd4, 13'(ANG_MAX), 24'd12800);
    write_reg(REG_HEADING, ANG_MAX);          // reduces modulo one turn
    send_column(10'd5, 13'd2431, 24'd12800);
    send_column(10'd6, 13'd5759, 24'd12800);
  endtask

  // Smallest and largest distances, with the heading back at zero
  task automatic test_distance_extremes();
    write_reg(REG_HEADING, 0);
    send_column(10'd1023, 13'd0, 24'd0);
    send_column(10'd0, 13'd0, 24'd1);        // tiny distance: height clips
    send_column(10'd1023, 13'd0, 24'hFFFFFF);
    send_column(10'd0, 13'd0, 24'd16384);
  endtask

  // Field of view at and past both clamps
  task automatic test_fov_limits();
    int unsigned fovs [5] = '{0, 1, FOV_MAX, FOV_MAX + 1, (1 << FOV_W) - 1};
    foreach (fovs[i]) begin
      write_reg(REG_FOV, fovs[i]);
      send_column(10'(i), 13'd0, 24'd2560);
    end
    write_reg(REG_FOV, 60);
  endtask

  // Block size zero (with and without a zero distance) and the large end
  task automatic test_block_size_limits();
    write_reg(REG_BLOCK, 0);
    send_column(10'd7, 13'd0, 24'd0);
    send_column(10'd8, 13'd0, 24'd5000);
    write_reg(REG_BLOCK, 1);
    send_column(10'd9, 13'd0, 24'd300);
    write_reg(REG_BLOCK, 1024);
    send_column(10'd10, 13'd0, 24'd9000);
    write_reg(REG_BLOCK, (1 << BLK_W) - 1);
    send_column(10'd11, 13'd0, 24'd70000);
  endtask

  // A write to the unused index must leave every register alone
  task automatic test_unused_register();
    write_reg(REG_UNUSED, (1 << CFG_DATA_W) - 1);
    send_column(10'd12, 13'd100, 24'd40000);
  endtask

  // Frames of random columns, each under a fresh register set
  task automatic test_random_frames();
    int unsigned fov, span, ray, pause_at;
    for (int frame = 0; frame < FRAMES; frame++) begin
      // Mostly sane settings, now and then the extremes
      write_reg(REG_HEADING, ($urandom_range(0, 7) == 0) ?
                $urandom_range(TURN, ANG_MAX) : $urandom_range(0, TURN - 1));
      case ($urandom_range(0, 5))
        0:       write_reg(REG_FOV, $urandom_range(0, 1));
        1:       write_reg(REG_FOV, $urandom_range(FOV_MAX, (1 << FOV_W) - 1));
        default: write_reg(REG_FOV, $urandom_range(20, 120));
      endcase
      case ($urandom_range(0, 7))
        0:       write_reg(REG_BLOCK, 0);
        1:       write_reg(REG_BLOCK, $urandom_range(1024, (1 << BLK_W) - 1));
        default: write_reg(REG_BLOCK, $urandom_range(1, 1024));
      endcase
      // Some frames run back to back with no gaps at all
      sender_gaps = ($urandom_range(0, 3) != 0);
      pause_at = $urandom_range(0, COLUMNS_PER_FRAME - 1);
      fov = (fov_reg < FOV_MIN) ? FOV_MIN : ((fov_reg > FOV_MAX) ? FOV_MAX : fov_reg);
      span = fov << (FOV_SHIFT + 1);
      for (int i = 0; i < COLUMNS_PER_FRAME; i++) begin
        if (i == pause_at) begin
          drain_results();
        end
        // Rays mostly inside the view cone, sometimes anywhere
        if ($urandom_range(0, 3) == 0) begin
          ray = $urandom_range(0, ANG_MAX);
        end else begin
          ray = ((heading_reg % TURN) + TURN + $urandom_range(0, span) - span / 2) % TURN;
          if ($urandom_range(0, 7) == 0 && ray + TURN <= ANG_MAX) begin
            ray += TURN;
          end
        end
        send_column(10'($urandom_range(0, (1 << COL_W) - 1)), 13'(ray),
                    random_distance());
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    start          = 1'b0;
    column_i       = '0;
    ray_angle_i    = '0;
    raw_distance_i = '0;
    build_sine_table();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_angle_wrap();
    test_distance_extremes();
    test_fov_limits();
    test_block_size_limits();
    test_unused_register();
    test_random_frames();

    // Let the last columns leave the pipeline, then look for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_spans.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
